### rtl/fixed_block_pool_allocator_macros.svh
// Assertion macros shared by the pool allocator RTL.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define FBPA_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FBPA_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/fbpa_pkg.sv
// Types and constants of the fixed block pool allocator.
package fbpa_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int LINK_W     = $clog2(MAX_BLOCKS + 1);

    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 17;
    localparam int COUNT_W    = 11;
    localparam int STRIDE_W   = 18;
    localparam int PROD_W     = IDX_W + STRIDE_W;
    localparam int DIV_CNT_W  = $clog2(ADDR_W);

    localparam int DATA_W     = 32;
    localparam int PADDR_W    = 4;

    localparam logic [LINK_W-1:0]   NULL_LINK    = LINK_W'(MAX_BLOCKS);
    localparam logic [ADDR_W-1:0]   HEADER_BYTES = 32'd12;
    localparam logic [STRIDE_W-1:0] LINK_BYTES   = 18'd4;
    localparam logic [STRIDE_W-1:0] ROUND_MASK   = 18'h3;

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_SIZE  = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ADDR_W-1:0] free_address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] block_address;
        logic [1:0]        status;
    } rsp_t;

endpackage

### rtl/fbpa_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module fbpa_div
    import fbpa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [ADDR_W-1:0]   dividend,
    input  logic [STRIDE_W-1:0] divisor,
    output logic                done,
    output logic [ADDR_W-1:0]   quot,
    output logic [STRIDE_W-1:0] rem
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [ADDR_W-1:0]    quot_reg, quot_next;
    logic [STRIDE_W-1:0]  rem_reg, rem_next;
    logic [STRIDE_W-1:0]  dvs_reg, dvs_next;

    logic [STRIDE_W:0]    trial;
    logic [STRIDE_W:0]    diff;
    logic                 ge;

    assign trial = {rem_reg, quot_reg[ADDR_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            cnt_next  = cnt_reg + DIV_CNT_W'(1);
            quot_next = {quot_reg[ADDR_W-2:0], ge};
            rem_next  = ge ? diff[STRIDE_W-1:0] : trial[STRIDE_W-1:0];
            if (cnt_reg == DIV_CNT_W'(ADDR_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

### rtl/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: sequencer, link memory, APB registers.
//
// channel | dir | handshake             | payload
// req     | in  | req_valid / req_stall | req_t: operation, free_address
// rsp     | out | rsp_valid / rsp_stall | rsp_t: block_address, status
// apb     | in  | psel / penable        | base_address, block_size, block_count
//
// Init: one link write per block. Alloc: link read, multiply, add; an empty pool skips to the response.
// Free: 32-step divider, then a range check; a list walk, if needed, reads one link
// per free block below the freed one before the two link writes.
// One request at a time; req_stall is high while a request is in flight.
// A finished response waits in the output register; the next request is taken meanwhile.
// Reset empties the free list; the link memory is not cleared.
`include "fixed_block_pool_allocator_macros.svh"

module fixed_block_pool_allocator
    import fbpa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               req_valid,
    output logic               req_stall,
    input  req_t               req,

    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rsp_t               rsp,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b0000000001,
        S_INIT      = 10'b0000000010,
        S_ALLOC_MUL = 10'b0000000100,
        S_ALLOC_ADD = 10'b0000001000,
        S_DIV       = 10'b0000010000,
        S_FREE_CHK  = 10'b0000100000,
        S_WALK      = 10'b0001000000,
        S_LINK_P    = 10'b0010000000,
        S_LINK_IDX  = 10'b0100000000,
        S_RESP      = 10'b1000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [LINK_W-1:0]   head_reg, head_next;
    logic [LINK_W-1:0]   cnt_reg, cnt_next;
    logic [LINK_W-1:0]   n_reg, n_next;
    logic [IDX_W-1:0]    p_reg, p_next;
    logic [LINK_W-1:0]   q_reg, q_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    rsp_t                res_reg, res_next;
    rsp_t                out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic [ADDR_W-1:0]   base_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [COUNT_W-1:0]  count_reg;

    logic [LINK_W-1:0]   link_mem [MAX_BLOCKS];
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [LINK_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [IDX_W-1:0]    mem_raddr;
    logic [LINK_W-1:0]   mem_rdata_reg;

    logic                div_start;
    logic                div_done;
    logic [ADDR_W-1:0]   div_quot;
    logic [STRIDE_W-1:0] div_rem;

    logic [STRIDE_W-1:0] size_up;
    logic [STRIDE_W-1:0] stride;
    logic [LINK_W-1:0]   pool_count;
    logic [ADDR_W-1:0]   first_addr;
    logic [LINK_W-1:0]   cnt_plus;
    logic [IDX_W-1:0]    chk_idx;
    logic [LINK_W-1:0]   chk_idx_ext;
    logic                cfg_write;

    // block geometry from the current registers
    assign size_up    = STRIDE_W'(size_reg) + ROUND_MASK;
    assign stride     = (size_up & ~ROUND_MASK) + LINK_BYTES;
    assign pool_count = (32'(count_reg) > 32'(MAX_BLOCKS)) ? LINK_W'(MAX_BLOCKS)
                                                           : LINK_W'(count_reg);
    assign first_addr = base_reg + HEADER_BYTES;
    assign cnt_plus   = cnt_reg + LINK_W'(1);
    assign chk_idx    = div_quot[IDX_W-1:0];
    assign chk_idx_ext = LINK_W'(chk_idx);

    fbpa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (req.free_address - first_addr),
        .divisor  (stride),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        idx_next       = idx_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        div_start      = 1'b0;

        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_next.block_address = '0;
                    res_next.status        = ST_OK;
                    case (req.operation)
                        OP_INIT:
                        begin
                            n_next     = pool_count;
                            cnt_next   = '0;
                            head_next  = (pool_count != '0) ? '0 : NULL_LINK;
                            state_next = (pool_count != '0) ? S_INIT : S_RESP;
                        end
                        OP_ALLOC:
                        begin
                            if (head_reg >= NULL_LINK)
                            begin
                                res_next.status = ST_EMPTY;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = head_reg[IDX_W-1:0];
                                state_next = S_ALLOC_MUL;
                            end
                        end
                        OP_FREE:
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[IDX_W-1:0];
                mem_wdata = (cnt_plus < n_reg) ? cnt_plus : NULL_LINK;
                cnt_next  = cnt_plus;
                if (cnt_plus >= n_reg)
                begin
                    state_next = S_RESP;
                end
            end
            S_ALLOC_MUL:
            begin
                prod_next  = PROD_W'(head_reg[IDX_W-1:0]) * PROD_W'(stride);
                head_next  = mem_rdata_reg;
                state_next = S_ALLOC_ADD;
            end
            S_ALLOC_ADD:
            begin
                res_next.block_address = first_addr + ADDR_W'(prod_reg);
                state_next             = S_RESP;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_FREE_CHK;
                end
            end
            S_FREE_CHK:
            begin
                if (div_rem != '0 || div_quot >= 32'(pool_count))
                begin
                    res_next.status = ST_BAD_FREE;
                    state_next      = S_RESP;
                end
                else
                begin
                    idx_next = chk_idx;
                    if (head_reg >= NULL_LINK)
                    begin
                        head_next  = chk_idx_ext;
                        mem_we     = 1'b1;
                        mem_waddr  = chk_idx;
                        mem_wdata  = NULL_LINK;
                        state_next = S_RESP;
                    end
                    else if (chk_idx_ext < head_reg)
                    begin
                        head_next  = chk_idx_ext;
                        mem_we     = 1'b1;
                        mem_waddr  = chk_idx;
                        mem_wdata  = head_reg;
                        state_next = S_RESP;
                    end
                    else if (head_reg < chk_idx_ext)
                    begin
                        p_next     = head_reg[IDX_W-1:0];
                        mem_re     = 1'b1;
                        mem_raddr  = head_reg[IDX_W-1:0];
                        cnt_next   = LINK_W'(1);
                        state_next = S_WALK;
                    end
                    else
                    begin
                        p_next     = head_reg[IDX_W-1:0];
                        q_next     = head_reg;
                        state_next = S_LINK_P;
                    end
                end
            end
            S_WALK:
            begin
                // the registered link read is the next list entry
                if (mem_rdata_reg < LINK_W'(idx_reg) && cnt_reg < LINK_W'(MAX_BLOCKS))
                begin
                    p_next    = mem_rdata_reg[IDX_W-1:0];
                    mem_re    = 1'b1;
                    mem_raddr = mem_rdata_reg[IDX_W-1:0];
                    cnt_next  = cnt_plus;
                end
                else
                begin
                    q_next     = mem_rdata_reg;
                    state_next = S_LINK_P;
                end
            end
            S_LINK_P:
            begin
                mem_we     = 1'b1;
                mem_waddr  = p_reg;
                mem_wdata  = LINK_W'(idx_reg);
                state_next = S_LINK_IDX;
            end
            S_LINK_IDX:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = q_reg;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= NULL_LINK;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        p_reg    <= p_next;
        q_reg    <= q_next;
        idx_reg  <= idx_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= link_mem[mem_raddr];
        end
    end

    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            size_reg  <= SIZE_W'(4);
            count_reg <= COUNT_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_BASE:  base_reg  <= pwdata;
                REG_SIZE:  size_reg  <= pwdata[SIZE_W-1:0];
                REG_COUNT: count_reg <= pwdata[COUNT_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_BASE:  prdata = base_reg;
            REG_SIZE:  prdata = DATA_W'(size_reg);
            REG_COUNT: prdata = DATA_W'(count_reg);
            default:   prdata = '0;
        endcase
    end

    assign pready    = 1'b1;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    `FBPA_ASSERT_NXT(a_free_starts_div, req_valid && !req_stall && req.operation == OP_FREE, state_reg == S_DIV, "free request did not start the divider")
    `FBPA_ASSERT_IMP(a_div_done_in_div, div_done, state_reg == S_DIV, "divider finished outside the divide state")
    `FBPA_ASSERT_IMP(a_walk_below_target, state_reg == S_WALK, p_reg < idx_reg, "list walk passed the freed block")
    `FBPA_ASSERT_IMP(a_init_in_range, state_reg == S_INIT, cnt_reg < n_reg, "init pass ran past the block count")

endmodule

### tb/tb.sv
// Self-checking testbench for the fixed block pool allocator: directed and random requests.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fbpa_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 1200;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    req_t               req       = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    rsp_t               rsp;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0]  pwdata    = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    // shadow registers and free-list state
    logic [ADDR_W-1:0]  cfg_base  = '0;
    logic [SIZE_W-1:0]  cfg_size  = SIZE_W'(4);
    logic [COUNT_W-1:0] cfg_count = COUNT_W'(1);
    logic [LINK_W-1:0]  head_idx  = NULL_LINK;
    logic [LINK_W-1:0]  link_mem [MAX_BLOCKS];

    rsp_t               expected_rsp_q [$];
    logic [ADDR_W-1:0]  live_blocks [$];
    rsp_t               oldest_rsp;
    int                 mismatch_count = 0;
    int                 gap_pct   = 0;
    int                 stall_pct = 0;
    int                 quiet_cycles;

    fixed_block_pool_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [STRIDE_W-1:0] stride_bytes();
        return ((STRIDE_W'(cfg_size) + ROUND_MASK) & ~ROUND_MASK) + LINK_BYTES;
    endfunction

    function automatic logic [COUNT_W-1:0] pool_blocks();
        return (cfg_count > COUNT_W'(MAX_BLOCKS)) ? COUNT_W'(MAX_BLOCKS) : cfg_count;
    endfunction

    function automatic logic [ADDR_W-1:0] first_addr();
        return cfg_base + HEADER_BYTES;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [ADDR_W-1:0] idx);
        return first_addr() + idx * ADDR_W'(stride_bytes());
    endfunction

    function automatic logic [LINK_W-1:0] link_at(input logic [ADDR_W-1:0] idx);
        return (idx < MAX_BLOCKS) ? link_mem[idx[IDX_W-1:0]] : NULL_LINK;
    endfunction

    function automatic void set_link(input logic [ADDR_W-1:0] idx, input logic [LINK_W-1:0] val);
        if (idx < MAX_BLOCKS)
            link_mem[idx[IDX_W-1:0]] = val;
    endfunction

    // applies one request to the free list and returns the response it should give
    function automatic rsp_t pool_update(input req_t r);
        rsp_t              res;
        logic [ADDR_W-1:0] off;
        logic [ADDR_W-1:0] idx;
        logic [LINK_W-1:0] p;
        logic [LINK_W-1:0] q;
        int                n;
        int                steps;
        int                hits [$];
        res.block_address = '0;
        res.status        = ST_OK;
        case (r.operation)
            OP_INIT:
            begin
                n = int'(pool_blocks());
                for (int i = 0; i < n; i++)
                    set_link(i, (i + 1 < n) ? LINK_W'(i + 1) : NULL_LINK);
                head_idx = (n > 0) ? '0 : NULL_LINK;
                live_blocks.delete();
            end
            OP_ALLOC:
            begin
                if (head_idx >= NULL_LINK)
                    res.status = ST_EMPTY;
                else
                begin
                    res.block_address = addr_of(head_idx);
                    live_blocks.push_back(res.block_address);
                    head_idx = link_at(head_idx);
                end
            end
            OP_FREE:
            begin
                off = r.free_address - first_addr();
                idx = off / ADDR_W'(stride_bytes());
                if ((off % ADDR_W'(stride_bytes())) != 0 || idx >= ADDR_W'(pool_blocks()))
                    res.status = ST_BAD_FREE;
                else
                begin
                    hits = live_blocks.find_first_index(x) with (x == r.free_address);
                    if (hits.size() != 0)
                        live_blocks.delete(hits[0]);
                    if (head_idx >= NULL_LINK)
                    begin
                        head_idx = idx[LINK_W-1:0];
                        set_link(idx, NULL_LINK);
                    end
                    else if (idx < head_idx)
                    begin
                        set_link(idx, head_idx);
                        head_idx = idx[LINK_W-1:0];
                    end
                    else
                    begin
                        p = head_idx;
                        q = head_idx;
                        steps = 0;
                        // bounded walk, a double free can leave a loop
                        while (q < idx && steps < MAX_BLOCKS)
                        begin
                            p = q;
                            q = link_at(q);
                            steps++;
                        end
                        set_link(p, idx[LINK_W-1:0]);
                        set_link(idx, q);
                    end
                end
            end
            default:
                ;
        endcase
        return res;
    endfunction

    function automatic void flag_error(input string what);
        if (mismatch_count < 10)
            $display("ERROR at %0t ns: %s", $time, what);
        mismatch_count++;
    endfunction

    task automatic send_req(input logic [1:0] op, input logic [ADDR_W-1:0] addr);
        req_t item;
        item.operation    = op;
        item.free_address = addr;
        while ($urandom_range(99) < gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
        expected_rsp_q.push_back(pool_update(item));
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({index, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_BASE:  cfg_base  = value;
            REG_SIZE:  cfg_size  = value[SIZE_W-1:0];
            REG_COUNT: cfg_count = value[COUNT_W-1:0];
            default:   ;
        endcase
        live_blocks.delete();
    endtask

    task automatic test_reset_state();
        send_req(OP_ALLOC, '1);
        send_req(OP_FREE, HEADER_BYTES);
        send_req(OP_ALLOC, '0);
        send_req(OP_UNUSED, 32'hA5A5_5A5A);
        wait_idle();
    endtask

    // pool whose first block wraps past the top of the address space
    task automatic test_wrapped_pool();
        write_reg(REG_BASE, 32'hFFFF_FFF8);
        write_reg(REG_SIZE, 32'd1);
        write_reg(REG_COUNT, 32'd3);
        send_req(OP_INIT, 32'h5A5A_A5A5);
        repeat (4)
            send_req(OP_ALLOC, $urandom());
        send_req(OP_FREE, addr_of(1));
        send_req(OP_FREE, addr_of(0));
        send_req(OP_FREE, addr_of(2));
        send_req(OP_FREE, addr_of(1));
        send_req(OP_FREE, addr_of(2));
        send_req(OP_FREE, first_addr() - 32'd4);
        send_req(OP_FREE, addr_of(3));
        send_req(OP_FREE, addr_of(0) + 32'd1);
        send_req(OP_INIT, '0);
        wait_idle();
    endtask

    task automatic test_count_limits();
        write_reg(REG_COUNT, 32'd0);
        send_req(OP_INIT, '0);
        send_req(OP_ALLOC, '0);
        wait_idle();
        write_reg(REG_BASE, 32'h8000_0000);
        write_reg(REG_SIZE, 32'h0001_FFFF);
        write_reg(REG_COUNT, 32'd2047);
        send_req(OP_INIT, '1);
        send_req(OP_ALLOC, '0);
        send_req(OP_FREE, addr_of(MAX_BLOCKS));
        send_req(OP_FREE, addr_of(MAX_BLOCKS - 1));
        send_req(OP_FREE, addr_of(0));
        wait_idle();
        // registers change under a live list
        write_reg(REG_BASE, 32'h0000_1000);
        send_req(OP_ALLOC, '0);
        wait_idle();
        write_reg(REG_SIZE, 32'd65536);
        send_req(OP_ALLOC, '0);
        wait_idle();
    endtask

    task automatic load_random_pool();
        logic [ADDR_W-1:0]  base;
        logic [SIZE_W-1:0]  size;
        logic [COUNT_W-1:0] count;
        int                 pick;
        case ($urandom_range(9))
            0:       base = '0;
            1:       base = '1;
            2:       base = 32'hFFFF_FF00 | $urandom_range(255);
            default: base = $urandom();
        endcase
        pick = $urandom_range(9);
        if (pick == 0)
            size = SIZE_W'(65536);
        else if (pick < 3)
            size = SIZE_W'($urandom_range(1, 65536));
        else
            size = SIZE_W'($urandom_range(1, 64));
        pick = $urandom_range(19);
        if (pick == 0)
            count = COUNT_W'(MAX_BLOCKS);
        else if (pick < 3)
            count = COUNT_W'($urandom_range(17, 128));
        else
            count = COUNT_W'($urandom_range(1, 16));
        write_reg(REG_BASE, base);
        write_reg(REG_SIZE, DATA_W'(size));
        write_reg(REG_COUNT, DATA_W'(count));
        send_req(OP_INIT, $urandom());
    endtask

    task automatic send_random_req();
        int                pick;
        logic [ADDR_W-1:0] noise;
        logic [ADDR_W-1:0] stride;
        logic [ADDR_W-1:0] n;
        pick   = $urandom_range(99);
        noise  = $urandom();
        stride = ADDR_W'(stride_bytes());
        n      = ADDR_W'(pool_blocks());
        if (pick < 40 || (pick < 75 && live_blocks.size() == 0) || n == 0)
            send_req(OP_ALLOC, noise);
        else if (pick < 75)
            send_req(OP_FREE, live_blocks[$urandom_range(live_blocks.size() - 1)]);
        else if (pick < 85)
            send_req(OP_FREE, addr_of($urandom_range(n - 1)));
        else if (pick < 88)
            send_req(OP_INIT, noise);
        else if (pick < 90)
            send_req(OP_UNUSED, noise);
        else
        begin
            case (pick % 4)
                0: send_req(OP_FREE, noise);
                1: send_req(OP_FREE, addr_of($urandom_range(n - 1)) +
                                     $urandom_range(1, stride - 1));
                2: send_req(OP_FREE, addr_of(n + $urandom_range(3)));
                default: send_req(OP_FREE, first_addr() - $urandom_range(1, 16));
            endcase
        end
    endtask

    task automatic test_random_phase(input int gap, input int stall);
        gap_pct   = gap;
        stall_pct = stall;
        repeat (3)
        begin
            load_random_pool();
            repeat (38)
                send_random_req();
            wait_idle();
        end
    endtask

    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp_q.size() == 0)
                flag_error($sformatf("unexpected response: block_address %h status %0d",
                                     rsp.block_address, rsp.status));
            else
            begin
                oldest_rsp = expected_rsp_q.pop_front();
                if (rsp.block_address !== oldest_rsp.block_address)
                    flag_error($sformatf("block_address expected %h got %h",
                                         oldest_rsp.block_address, rsp.block_address));
                if (rsp.status !== oldest_rsp.status)
                    flag_error($sformatf("status expected %0d got %0d",
                                         oldest_rsp.status, rsp.status));
            end
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_wrapped_pool();
        test_count_limits();
        test_random_phase(0, 0);
        test_random_phase(58, 0);
        test_random_phase(0, 58);
        test_random_phase(33, 33);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0 && expected_rsp_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
